### rtl/core/aaru_pkg.sv
package aaru_pkg;

	localparam int SAMPLE_W   = 13;
	localparam int CNT_W      = 9;
	localparam int SUM_W      = 21;
	localparam int AVG_W      = 21;
	localparam int PCT_W      = 15;
	localparam int VOLT_W     = 21;
	localparam int FS_W       = 13;
	localparam int SEL_W      = 3;
	localparam int FRAC_W     = 8;
	localparam int DIVD_W     = SUM_W + FRAC_W;
	localparam int MA_W       = 21;
	localparam int MB_W       = 13;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int DQ_W       = 21;
	localparam int STEP_W     = 5;
	localparam int SHIFT_W    = 4;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 2;

	localparam int AVG_STEPS  = 21;
	localparam int MUL_STEPS  = 13;
	localparam int PCT_STEPS  = 15;
	localparam int PCT_MUL_W  = 28;

	localparam int MAX_AVERAGE  = 256;
	localparam int BITS_BASE    = 9;
	localparam int SEL_MAX      = 4;
	localparam int SEL_DEFAULT  = 3;
	localparam int PCT_SCALE    = 100;
	localparam int PCT_FULL     = PCT_SCALE << FRAC_W;
	localparam int VOLT_LIMIT   = 5000 << FRAC_W;
	localparam int MIN_START    = 200 << FRAC_W;
	localparam int MAX_START    = 3000 << FRAC_W;

	localparam int AVG_COUNT_RESET  = 16;
	localparam int BITS_SEL_RESET   = 3;
	localparam int FULL_SCALE_RESET = 3300;

	localparam logic [REG_IDX_W-1:0] REG_AVG_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BITS_SEL   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] avg_count;
		logic [SEL_W-1:0] bits_sel;
		logic [FS_W-1:0]  full_scale;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
	} unit_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_LOAD,
		ST_AVG_DIV,
		ST_RANGE,
		ST_VOLT_MUL,
		ST_PCT_LOAD,
		ST_PCT_MUL,
		ST_PCT_DIVLD,
		ST_PCT_DIV,
		ST_FINISH
	} state_t;

endpackage

### rtl/core/aaru_regs.sv
module aaru_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [aaru_pkg::ADDR_W-1:0]    paddr,
	input  logic [aaru_pkg::DATA_W-1:0]    pwdata,
	output logic [aaru_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output aaru_pkg::cfg_t                 cfg
);

	logic [aaru_pkg::CNT_W-1:0]     avg_count_q;
	logic [aaru_pkg::SEL_W-1:0]     bits_sel_q;
	logic [aaru_pkg::FS_W-1:0]      full_scale_q;
	logic [aaru_pkg::REG_IDX_W-1:0] idx;

	assign idx    = paddr[aaru_pkg::ADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q  <= aaru_pkg::CNT_W'(aaru_pkg::AVG_COUNT_RESET);
			bits_sel_q   <= aaru_pkg::SEL_W'(aaru_pkg::BITS_SEL_RESET);
			full_scale_q <= aaru_pkg::FS_W'(aaru_pkg::FULL_SCALE_RESET);
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				aaru_pkg::REG_AVG_COUNT:  avg_count_q  <= pwdata[aaru_pkg::CNT_W-1:0];
				aaru_pkg::REG_BITS_SEL:   bits_sel_q   <= pwdata[aaru_pkg::SEL_W-1:0];
				aaru_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[aaru_pkg::FS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			aaru_pkg::REG_AVG_COUNT:  prdata = aaru_pkg::DATA_W'(avg_count_q);
			aaru_pkg::REG_BITS_SEL:   prdata = aaru_pkg::DATA_W'(bits_sel_q);
			aaru_pkg::REG_FULL_SCALE: prdata = aaru_pkg::DATA_W'(full_scale_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.avg_count  = avg_count_q;
	assign cfg.bits_sel   = bits_sel_q;
	assign cfg.full_scale = full_scale_q;

endmodule

### rtl/core/aaru_mul.sv
module aaru_mul (
	input  logic                          clk,
	input  aaru_pkg::unit_ctrl_t          ctrl,
	input  logic [aaru_pkg::MA_W-1:0]     a,
	input  logic [aaru_pkg::MB_W-1:0]     b,
	output logic [aaru_pkg::PROD_W-1:0]   prod
);

	logic [aaru_pkg::MA_W-1:0]   a_q;
	logic [aaru_pkg::PROD_W-1:0] p_q;
	logic [aaru_pkg::MA_W:0]     psum;

	// one multiplier bit per cycle, lsb first
	assign psum = {1'b0, p_q[aaru_pkg::PROD_W-1:aaru_pkg::MB_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= a;
			p_q <= {{aaru_pkg::MA_W{1'b0}}, b};
		end else if (ctrl.step) begin
			p_q <= {psum, p_q[aaru_pkg::MB_W-1:1]};
		end
	end

	assign prod = p_q;

endmodule

### rtl/core/aaru_div.sv
module aaru_div (
	input  logic                        clk,
	input  aaru_pkg::unit_ctrl_t        ctrl,
	input  logic [aaru_pkg::DQ_W-1:0]   divisor,
	input  logic [aaru_pkg::DQ_W-1:0]   rem_init,
	input  logic [aaru_pkg::DQ_W-1:0]   low_init,
	output logic [aaru_pkg::DQ_W-1:0]   quotient
);

	logic [aaru_pkg::DQ_W-1:0] dvs_q;
	logic [aaru_pkg::DQ_W-1:0] rem_q;
	logic [aaru_pkg::DQ_W-1:0] low_q;
	logic [aaru_pkg::DQ_W-1:0] quo_q;
	logic [aaru_pkg::DQ_W:0]   trial;
	logic [aaru_pkg::DQ_W:0]   diff;
	logic                      ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, low_q[aaru_pkg::DQ_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dvs_q <= divisor;
			rem_q <= rem_init;
			low_q <= low_init;
			quo_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= ge ? diff[aaru_pkg::DQ_W-1:0] : trial[aaru_pkg::DQ_W-1:0];
			low_q <= {low_q[aaru_pkg::DQ_W-2:0], 1'b0};
			quo_q <= {quo_q[aaru_pkg::DQ_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

### rtl/core/adc_average_autorange_unit.sv
// results: a failed read gives its result on the next cycle; a completing sample passes
// AVG_LOAD, AVG_DIV, RANGE, VOLT_MUL, PCT_LOAD, PCT_MUL, PCT_DIVLD, PCT_DIV and FINISH
// input: one sample per cycle while the result slot is free, until an average completes;
// none then while the bit-serial divider (21 + 15 steps) and multiplier (2 x 13 steps) run
// reset: async, clears sum, count and handshakes, restores registers to defaults and the
// running range to 200..3000 counts
module adc_average_autorange_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aaru_pkg::ADDR_W-1:0]       paddr,
	input  logic [aaru_pkg::DATA_W-1:0]       pwdata,
	output logic [aaru_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [aaru_pkg::SAMPLE_W-1:0]     sample_value,
	input  logic                              read_failed,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              status,
	output logic [aaru_pkg::AVG_W-1:0]        average_q8,
	output logic [aaru_pkg::PCT_W-1:0]        percent_q8,
	output logic [aaru_pkg::VOLT_W-1:0]       voltage_mv_q8
);

	aaru_pkg::cfg_t       cfg;
	aaru_pkg::unit_ctrl_t mul_ctrl;
	aaru_pkg::unit_ctrl_t div_ctrl;
	aaru_pkg::state_t     state_q;
	aaru_pkg::state_t     state_d;

	logic [aaru_pkg::STEP_W-1:0]  cnt_q;
	logic                         step_last;
	logic                         step_state;
	logic                         finish;

	logic [aaru_pkg::SUM_W-1:0]   sum_q;
	logic [aaru_pkg::CNT_W-1:0]   count_q;
	logic [aaru_pkg::SUM_W-1:0]   sum_next;
	logic [aaru_pkg::CNT_W-1:0]   count_next;
	logic [aaru_pkg::CNT_W-1:0]   eff_count;
	logic                         accept;
	logic                         complete;

	logic [aaru_pkg::AVG_W-1:0]   avg_q;
	logic [aaru_pkg::AVG_W-1:0]   min_q;
	logic [aaru_pkg::AVG_W-1:0]   max_q;
	logic [aaru_pkg::VOLT_W-1:0]  volt_q;

	logic [aaru_pkg::DIVD_W-1:0]  avg_dividend;
	logic [aaru_pkg::PCT_MUL_W-1:0] pct_prod;
	logic [aaru_pkg::DQ_W-1:0]    div_divisor;
	logic [aaru_pkg::DQ_W-1:0]    div_rem;
	logic [aaru_pkg::DQ_W-1:0]    div_low;
	logic [aaru_pkg::DQ_W-1:0]    div_quo;
	logic [aaru_pkg::MA_W-1:0]    mul_a;
	logic [aaru_pkg::MB_W-1:0]    mul_b;
	logic [aaru_pkg::PROD_W-1:0]  mul_p;

	logic [aaru_pkg::SEL_W-1:0]   sel_eff;
	logic [aaru_pkg::SHIFT_W-1:0] shamt;
	logic [aaru_pkg::PROD_W-1:0]  volt_shift;
	logic [aaru_pkg::VOLT_W-1:0]  volt_sat;
	logic [aaru_pkg::PCT_W-1:0]   pct_val;

	logic                         out_valid_q;
	logic                         status_q;
	logic [aaru_pkg::AVG_W-1:0]   avg_out_q;
	logic [aaru_pkg::PCT_W-1:0]   pct_out_q;
	logic [aaru_pkg::VOLT_W-1:0]  volt_out_q;

	aaru_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aaru_mul u_mul (
		.clk  (clk),
		.ctrl (mul_ctrl),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	aaru_div u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.divisor  (div_divisor),
		.rem_init (div_rem),
		.low_init (div_low),
		.quotient (div_quo)
	);

	always_comb begin
		if (cfg.avg_count == '0) begin
			eff_count = aaru_pkg::CNT_W'(1);
		end else if (cfg.avg_count > aaru_pkg::CNT_W'(aaru_pkg::MAX_AVERAGE)) begin
			eff_count = aaru_pkg::CNT_W'(aaru_pkg::MAX_AVERAGE);
		end else begin
			eff_count = cfg.avg_count;
		end
	end

	assign accept     = sample_valid && sample_ready;
	assign sum_next   = sum_q + aaru_pkg::SUM_W'(sample_value);
	assign count_next = count_q + 1'b1;
	assign complete   = count_next >= eff_count;

	always_comb begin
		state_d = state_q;
		case (state_q)
			aaru_pkg::ST_IDLE: begin
				if (accept && !read_failed && complete) state_d = aaru_pkg::ST_AVG_LOAD;
			end
			aaru_pkg::ST_AVG_LOAD:  state_d = aaru_pkg::ST_AVG_DIV;
			aaru_pkg::ST_AVG_DIV: begin
				if (step_last) state_d = aaru_pkg::ST_RANGE;
			end
			aaru_pkg::ST_RANGE:     state_d = aaru_pkg::ST_VOLT_MUL;
			aaru_pkg::ST_VOLT_MUL: begin
				if (step_last) state_d = aaru_pkg::ST_PCT_LOAD;
			end
			aaru_pkg::ST_PCT_LOAD:  state_d = aaru_pkg::ST_PCT_MUL;
			aaru_pkg::ST_PCT_MUL: begin
				if (step_last) state_d = aaru_pkg::ST_PCT_DIVLD;
			end
			aaru_pkg::ST_PCT_DIVLD: state_d = aaru_pkg::ST_PCT_DIV;
			aaru_pkg::ST_PCT_DIV: begin
				if (step_last) state_d = aaru_pkg::ST_FINISH;
			end
			aaru_pkg::ST_FINISH:    state_d = aaru_pkg::ST_IDLE;
			default:                state_d = aaru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_ctrl     = '0;
		div_ctrl     = '0;
		sample_ready = 1'b0;
		step_state   = 1'b0;
		step_last    = 1'b0;
		finish       = 1'b0;
		case (state_q)
			aaru_pkg::ST_IDLE:      sample_ready = !out_valid_q || result_ready;
			aaru_pkg::ST_AVG_LOAD:  div_ctrl.load = 1'b1;
			aaru_pkg::ST_AVG_DIV: begin
				div_ctrl.step = 1'b1;
				step_state    = 1'b1;
				step_last     = cnt_q == aaru_pkg::STEP_W'(aaru_pkg::AVG_STEPS - 1);
			end
			aaru_pkg::ST_RANGE:     mul_ctrl.load = 1'b1;
			aaru_pkg::ST_VOLT_MUL: begin
				mul_ctrl.step = 1'b1;
				step_state    = 1'b1;
				step_last     = cnt_q == aaru_pkg::STEP_W'(aaru_pkg::MUL_STEPS - 1);
			end
			aaru_pkg::ST_PCT_LOAD:  mul_ctrl.load = 1'b1;
			aaru_pkg::ST_PCT_MUL: begin
				mul_ctrl.step = 1'b1;
				step_state    = 1'b1;
				step_last     = cnt_q == aaru_pkg::STEP_W'(aaru_pkg::MUL_STEPS - 1);
			end
			aaru_pkg::ST_PCT_DIVLD: div_ctrl.load = 1'b1;
			aaru_pkg::ST_PCT_DIV: begin
				div_ctrl.step = 1'b1;
				step_state    = 1'b1;
				step_last     = cnt_q == aaru_pkg::STEP_W'(aaru_pkg::PCT_STEPS - 1);
			end
			aaru_pkg::ST_FINISH:    finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aaru_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (step_state && !step_last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// divider and multiplier operand selection
	assign avg_dividend = {sum_q, {aaru_pkg::FRAC_W{1'b0}}}
		+ aaru_pkg::DIVD_W'(count_q >> 1);
	assign pct_prod     = mul_p[aaru_pkg::PCT_MUL_W-1:0];

	always_comb begin
		if (state_q == aaru_pkg::ST_AVG_LOAD) begin
			div_divisor = aaru_pkg::DQ_W'(count_q);
			div_rem     = aaru_pkg::DQ_W'(avg_dividend[aaru_pkg::DIVD_W-1:aaru_pkg::DQ_W]);
			div_low     = avg_dividend[aaru_pkg::DQ_W-1:0];
		end else begin
			div_divisor = max_q - min_q;
			div_rem     = pct_prod[aaru_pkg::PCT_MUL_W-1:aaru_pkg::PCT_MUL_W-aaru_pkg::DQ_W];
			div_low     = {pct_prod[aaru_pkg::PCT_MUL_W-aaru_pkg::DQ_W-1:0],
				{(2*aaru_pkg::DQ_W-aaru_pkg::PCT_MUL_W){1'b0}}};
		end
	end

	always_comb begin
		if (state_q == aaru_pkg::ST_RANGE) begin
			mul_a = div_quo;
			mul_b = cfg.full_scale;
		end else begin
			mul_a = avg_q - min_q;
			mul_b = aaru_pkg::MB_W'(aaru_pkg::PCT_SCALE);
		end
	end

	assign sel_eff    = (cfg.bits_sel > aaru_pkg::SEL_W'(aaru_pkg::SEL_MAX))
		? aaru_pkg::SEL_W'(aaru_pkg::SEL_DEFAULT) : cfg.bits_sel;
	assign shamt      = aaru_pkg::SHIFT_W'(aaru_pkg::BITS_BASE) + aaru_pkg::SHIFT_W'(sel_eff);
	assign volt_shift = mul_p >> shamt;
	assign volt_sat   = (volt_shift > aaru_pkg::PROD_W'(aaru_pkg::VOLT_LIMIT))
		? aaru_pkg::VOLT_W'(aaru_pkg::VOLT_LIMIT) : volt_shift[aaru_pkg::VOLT_W-1:0];

	always_comb begin
		if (max_q <= min_q) begin
			pct_val = '0;
		end else if (div_quo > aaru_pkg::DQ_W'(aaru_pkg::PCT_FULL)) begin
			pct_val = aaru_pkg::PCT_W'(aaru_pkg::PCT_FULL);
		end else begin
			pct_val = div_quo[aaru_pkg::PCT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= aaru_pkg::AVG_W'(aaru_pkg::MIN_START);
			max_q   <= aaru_pkg::AVG_W'(aaru_pkg::MAX_START);
		end else begin
			if (accept) begin
				if (read_failed) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end else if (state_q == aaru_pkg::ST_AVG_LOAD) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (state_q == aaru_pkg::ST_RANGE) begin
				if (div_quo > max_q) max_q <= div_quo;
				if (div_quo < min_q) min_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aaru_pkg::ST_RANGE) avg_q <= div_quo;
		if (state_q == aaru_pkg::ST_PCT_LOAD) volt_q <= volt_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && read_failed) || finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && read_failed) begin
			status_q   <= 1'b1;
			avg_out_q  <= '0;
			pct_out_q  <= '0;
			volt_out_q <= '0;
		end else if (finish) begin
			status_q   <= 1'b0;
			avg_out_q  <= avg_q;
			pct_out_q  <= pct_val;
			volt_out_q <= volt_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign status        = status_q;
	assign average_q8    = avg_out_q;
	assign percent_q8    = pct_out_q;
	assign voltage_mv_q8 = volt_out_q;

`ifndef SYNTH
	a_fail_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && read_failed) |=> (result_valid && status))
		else $error("failed read did not produce an error result");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		min_q < max_q)
		else $error("running range collapsed");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aaru_pkg::ST_FINISH) |-> !out_valid_q)
		else $error("result written over a pending result");

	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aaru_pkg::ST_FINISH) |-> (div_quo <= aaru_pkg::DQ_W'(aaru_pkg::PCT_FULL)))
		else $error("percent quotient out of range");
`endif

endmodule
